[rtl/bpu_pkg.sv]
// ============================================================================
// bpu_pkg
// Shared types, codes and helpers for the bit packer / unpacker unit.
// ============================================================================
package bpu_pkg;

   // Largest buffer size in 32-bit words
   localparam logic [14:0] MAX_WORDS = 15'd16384;

   // Configuration port address width (two 32-bit registers)
   localparam int CSR_ADDR_W = 3;

   // Stream modes
   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_READ    = 2'd1,
      MODE_MEASURE = 2'd2,
      MODE_BAD     = 2'd3
   } bpu_mode_type;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_FIELD = 2'd0,
      REQ_ALIGN = 2'd1,
      REQ_FLUSH = 2'd2,
      REQ_BAD   = 2'd3
   } bpu_req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_OVERFLOW = 2'd1,
      STAT_INVALID  = 2'd2
   } bpu_status_type;

   // Register indexes (taken from address bit 2)
   typedef enum logic {
      REG_STREAM_MODE = 1'b0,
      REG_CAPACITY    = 1'b1
   } bpu_reg_type;

   // Request transaction payload
   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] value_in;
      logic [5:0]  bit_count;
      logic [31:0] fresh_word;
   } bpu_req_type;

   // Result transaction payload
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
      logic [31:0] word_out;
      logic        word_out_valid;
      logic        word_taken;
      logic [19:0] bits_done;
   } bpu_rsp_type;

   // Reverse the byte order of a 32-bit word
   function automatic logic [31:0] swap_bytes(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

[rtl/bit_packer_unpacker_unit.sv]
// ============================================================================
// bit_packer_unpacker_unit
// Packs or unpacks fields of 1 to 32 bits into big-endian 32-bit words, or only counts them.
// ============================================================================
// Each request transaction is worked on directly against the 64-bit
// scratch register and its result is held in an output register, so a new
// request is taken every cycle while the result side keeps up, and the
// result is offered in the cycle after its request is taken. Throughput is
// one request per clock while the result side keeps up, set by the shift,
// mask and OR on the scratch register together with the capacity compare.
// Writing either configuration register restarts the stream; write them
// only while no request is in flight.
module bit_packer_unpacker_unit
   import bpu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bpu_req_type           req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bpu_rsp_type           rsp_data,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Configuration registers
   logic [1:0]  mode_ff;
   logic [14:0] capacity_ff;

   // Stream state
   logic [63:0] scratch_ff,  scratch_in;
   logic [6:0]  fill_ff,     fill_in;
   logic [14:0] wpos_ff,     wpos_in;
   logic [19:0] total_ff,    total_in;

   // Result register
   logic        rsp_valid_ff;
   bpu_rsp_type rsp_data_ff, rsp_data_in;

   // Working signals
   logic        accept;
   logic        csr_write;
   bpu_reg_type csr_index;
   logic [14:0] cap_words;
   logic [19:0] cap_bits;
   logic [2:0]  pad;
   logic [5:0]  nbits;
   logic        do_bits;
   logic [31:0] field_value;
   logic [63:0] mask;
   logic [63:0] merged;
   logic [6:0]  new_fill;
   logic [20:0] total_sum;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = bpu_reg_type'(csr_paddr[2]);

   // Read back the addressed register
   always_comb begin
      case (csr_index)
         REG_STREAM_MODE: csr_prdata = {30'd0, mode_ff};
         REG_CAPACITY:    csr_prdata = {17'd0, capacity_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   // Take a request whenever the result register is free or being drained
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective capacity in words and bits
   assign cap_words = (capacity_ff > MAX_WORDS) ? MAX_WORDS : capacity_ff;
   assign cap_bits  = {cap_words, 5'd0};

   // Zero bits needed to reach the next byte boundary
   assign pad = 3'd0 - total_ff[2:0];

   // Work out the next state and the result of the current transaction
   always_comb begin
      scratch_in  = scratch_ff;
      fill_in     = fill_ff;
      wpos_in     = wpos_ff;
      total_in    = total_ff;
      rsp_data_in = '0;
      rsp_data_in.status = STAT_OK;

      nbits       = (req_data.req_type == REQ_FIELD) ? req_data.bit_count : {3'd0, pad};
      field_value = (req_data.req_type == REQ_FIELD) ? req_data.value_in : 32'd0;
      mask        = (64'd1 << nbits) - 64'd1;
      merged      = scratch_ff;
      new_fill    = fill_ff + {1'b0, nbits};
      total_sum   = {1'b0, total_ff} + {15'd0, nbits};
      do_bits     = 1'b0;

      if (mode_ff == MODE_BAD || req_data.req_type == REQ_BAD) begin
         rsp_data_in.status = STAT_INVALID;
      end else if (req_data.req_type == REQ_FLUSH) begin
         // Emit the partial word in write mode
         if (mode_ff != MODE_WRITE) begin
            rsp_data_in.status = STAT_INVALID;
         end else if (fill_ff != 7'd0) begin
            if (wpos_ff >= cap_words) begin
               rsp_data_in.status = STAT_OVERFLOW;
            end else begin
               rsp_data_in.word_out       = swap_bytes(scratch_ff[31:0]);
               rsp_data_in.word_out_valid = 1'b1;
               wpos_in    = wpos_ff + 15'd1;
               scratch_in = '0;
               fill_in    = '0;
            end
         end
      end else if (req_data.req_type == REQ_FIELD) begin
         if (req_data.bit_count == 6'd0 || req_data.bit_count > 6'd32) begin
            rsp_data_in.status = STAT_INVALID;
         end else begin
            do_bits = 1'b1;
         end
      end else begin
         do_bits = (pad != 3'd0);
      end

      if (do_bits) begin
         if (mode_ff == MODE_MEASURE) begin
            // Count only, saturating
            total_in = total_sum[20] ? 20'hFFFFF : total_sum[19:0];
         end else if (total_sum > {1'b0, cap_bits}) begin
            rsp_data_in.status = STAT_OVERFLOW;
         end else if (mode_ff == MODE_WRITE) begin
            // Pack the field above the bits already held
            if (new_fill >= 7'd32 && wpos_ff >= cap_words) begin
               rsp_data_in.status = STAT_OVERFLOW;
            end else begin
               merged = scratch_ff | (({32'd0, field_value} & mask) << fill_ff);
               if (new_fill >= 7'd32) begin
                  rsp_data_in.word_out       = swap_bytes(merged[31:0]);
                  rsp_data_in.word_out_valid = 1'b1;
                  scratch_in = merged >> 32;
                  fill_in    = new_fill - 7'd32;
                  wpos_in    = wpos_ff + 15'd1;
               end else begin
                  scratch_in = merged;
                  fill_in    = new_fill;
               end
               total_in = total_sum[19:0];
            end
         end else begin
            // Read mode: take the offered word when the scratch runs short
            if (fill_ff < {1'b0, nbits} && wpos_ff >= cap_words) begin
               rsp_data_in.status = STAT_OVERFLOW;
            end else begin
               if (fill_ff < {1'b0, nbits}) begin
                  merged = scratch_ff | ({32'd0, swap_bytes(req_data.fresh_word)} << fill_ff);
                  rsp_data_in.word_taken = 1'b1;
                  wpos_in = wpos_ff + 15'd1;
                  fill_in = fill_ff + 7'd32 - {1'b0, nbits};
               end else begin
                  fill_in = fill_ff - {1'b0, nbits};
               end
               if (req_data.req_type == REQ_FIELD) begin
                  rsp_data_in.value_out = merged[31:0] & mask[31:0];
               end
               scratch_in = merged >> nbits;
               total_in   = total_sum[19:0];
            end
         end
      end

      rsp_data_in.bits_done = total_in;
   end

   // Configuration registers and stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WRITE;
         capacity_ff <= MAX_WORDS;
         scratch_ff  <= '0;
         fill_ff     <= '0;
         wpos_ff     <= '0;
         total_ff    <= '0;
      end else if (csr_write) begin
         // Restart the stream on any register write
         case (csr_index)
            REG_STREAM_MODE: mode_ff     <= csr_pwdata[1:0];
            REG_CAPACITY:    capacity_ff <= csr_pwdata[14:0];
            default:         mode_ff     <= mode_ff;
         endcase
         scratch_ff <= '0;
         fill_ff    <= '0;
         wpos_ff    <= '0;
         total_ff   <= '0;
      end else if (accept) begin
         scratch_ff <= scratch_in;
         fill_ff    <= fill_in;
         wpos_ff    <= wpos_in;
         total_ff   <= total_in;
      end
   end

   // Result register: load on accept, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bit packer / unpacker unit.
// ----------------------------------------------------------------------------
// Request transactions come from a backlog queue and are driven by a clocked
// driver. Every accepted request is run through a local model of the
// scratch-register packer, and the predicted result is queued. The monitor
// compares each result transaction, field by field, with the oldest one due.
// The run passes through several stream modes and capacities, with and
// without idle cycles on either channel.
module tb;
   import bpu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TOTAL_CAP   = 1048575;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   bpu_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   bpu_rsp_type           rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // request backlog and results still due
   bpu_req_type request_backlog[$];
   bpu_rsp_type result_due[$];
   bpu_rsp_type due_now;
   bpu_rsp_type predicted;

   int errors = 0;
   int cycle_count = 0;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   bit req_taken = 1'b0;

   // model of the packer state and its configuration
   bpu_mode_type mode_cfg = MODE_WRITE;
   int           cap_words = 16384;
   logic [63:0]  scratch = '0;
   int           fill = 0;
   int           word_pos = 0;
   int           bits_total = 0;

   bit_packer_unpacker_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Reverse the byte order of a word (buffer words travel big-endian)
   function automatic logic [31:0] byte_rev(input logic [31:0] x);
      logic [31:0] y;
      for (int i = 0; i < 4; i++) y[8*i +: 8] = x[8*(3-i) +: 8];
      return y;
   endfunction

   function automatic int usable_words();
      return (cap_words < int'(MAX_WORDS)) ? cap_words : int'(MAX_WORDS);
   endfunction

   function automatic void clear_stream();
      scratch = '0;
      fill = 0;
      word_pos = 0;
      bits_total = 0;
   endfunction

   // Move n bits through the scratch register: pack, unpack or only count
   task automatic shift_bits(input int n, input logic [31:0] value, input bit is_field,
                             input logic [31:0] fresh, inout bpu_rsp_type r);
      logic [63:0] mask;
      int room;
      mask = (64'd1 << n) - 64'd1;
      room = usable_words();
      if (mode_cfg == MODE_MEASURE) begin
         bits_total = (bits_total + n > TOTAL_CAP) ? TOTAL_CAP : bits_total + n;
      end else if (bits_total + n > room * 32) begin
         r.status = STAT_OVERFLOW;
      end else if (mode_cfg == MODE_WRITE) begin
         if (fill + n >= 32 && word_pos >= room) begin
            r.status = STAT_OVERFLOW;
         end else begin
            scratch |= ({32'd0, value} & mask) << fill;
            fill += n;
            // emit a full word, low 32 bits first
            if (fill >= 32) begin
               r.word_out = byte_rev(scratch[31:0]);
               r.word_out_valid = 1'b1;
               scratch >>= 32;
               fill -= 32;
               word_pos++;
            end
            bits_total += n;
         end
      end else begin
         if (fill < n && word_pos >= room) begin
            r.status = STAT_OVERFLOW;
         end else begin
            // take the offered word only when the scratch runs short
            if (fill < n) begin
               scratch |= {32'd0, byte_rev(fresh)} << fill;
               fill += 32;
               word_pos++;
               r.word_taken = 1'b1;
            end
            if (is_field) r.value_out = scratch[31:0] & mask[31:0];
            scratch >>= n;
            fill -= n;
            bits_total += n;
         end
      end
   endtask

   // Work out the result of one request transaction and advance the model
   task automatic pack_unpack_step(input bpu_req_type rq, output bpu_rsp_type r);
      int pad;
      r = '0;
      if (mode_cfg == MODE_BAD || rq.req_type == REQ_BAD) begin
         r.status = STAT_INVALID;
      end else if (rq.req_type == REQ_FLUSH) begin
         if (mode_cfg != MODE_WRITE) begin
            r.status = STAT_INVALID;
         end else if (fill > 0) begin
            if (word_pos >= usable_words()) begin
               r.status = STAT_OVERFLOW;
            end else begin
               r.word_out = byte_rev(scratch[31:0]);
               r.word_out_valid = 1'b1;
               word_pos++;
               scratch = '0;
               fill = 0;
            end
         end
      end else if (rq.req_type == REQ_FIELD) begin
         if (rq.bit_count < 1 || rq.bit_count > 32) r.status = STAT_INVALID;
         else shift_bits(rq.bit_count, rq.value_in, 1'b1, rq.fresh_word, r);
      end else begin
         pad = (8 - (bits_total & 7)) & 7;
         if (pad > 0) shift_bits(pad, 32'd0, 1'b0, rq.fresh_word, r);
      end
      r.bits_done = bits_total[19:0];
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Sample both channels and the configuration port at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_due.size() == 0) begin
               $display("%0t ns: result expected none, got %h", $time, rsp_data);
               errors++;
            end else begin
               due_now = result_due.pop_front();
               check_field("status", due_now.status, rsp_data.status);
               check_field("value_out", due_now.value_out, rsp_data.value_out);
               check_field("word_out", due_now.word_out, rsp_data.word_out);
               check_field("word_out_valid", due_now.word_out_valid,
                           rsp_data.word_out_valid);
               check_field("word_taken", due_now.word_taken, rsp_data.word_taken);
               check_field("bits_done", due_now.bits_done, rsp_data.bits_done);
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            pack_unpack_step(req_data, predicted);
            result_due.push_back(predicted);
         end
         // a register write restarts the stream
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_STREAM_MODE) mode_cfg = bpu_mode_type'(csr_pwdata[1:0]);
            else cap_words = int'(csr_pwdata[14:0]);
            clear_stream();
         end
      end
   end

   // Drive the next request, or hold the current one until it is accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_data <= request_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic bpu_req_type request_of(input bpu_req_kind_type kind,
                                              input logic [31:0] value,
                                              input int bits,
                                              input logic [31:0] fresh);
      bpu_req_type rq;
      rq.req_type = kind;
      rq.value_in = value;
      rq.bit_count = 6'(bits);
      rq.fresh_word = fresh;
      return rq;
   endfunction

   // Mostly well-formed fields, with aligns, flushes and malformed requests
   function automatic bpu_req_type random_request();
      bpu_req_kind_type kind;
      int r;
      int bits;
      r = $urandom_range(99);
      if (r < 72) kind = REQ_FIELD;
      else if (r < 84) kind = REQ_ALIGN;
      else if (r < 94) kind = REQ_FLUSH;
      else kind = REQ_BAD;
      r = $urandom_range(99);
      if (r < 8) bits = 1;
      else if (r < 16) bits = 32;
      else if (r < 85) bits = $urandom_range(32, 1);
      else if (r < 92) bits = 0;
      else bits = $urandom_range(63, 33);
      return request_of(kind, $urandom(), bits, $urandom());
   endfunction

   task automatic wait_drained();
      while (request_backlog.size() != 0 || req_valid || result_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input bpu_reg_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_check(input bpu_reg_type idx, input logic [31:0] want);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr readback", want, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Restart the stream with a new mode and capacity once the unit is idle
   task automatic set_stream(input bpu_mode_type m, input logic [14:0] cap);
      wait_drained();
      csr_write(REG_STREAM_MODE, {30'd0, m});
      csr_write(REG_CAPACITY, {17'd0, cap});
      csr_check(REG_STREAM_MODE, {30'd0, m});
      csr_check(REG_CAPACITY, {17'd0, cap});
      @(posedge clock);
   endtask

   task automatic set_idle(input int kind);
      case (kind)
         0: begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_gap_pct = 49;
            rsp_stall_pct = 0;
         end
         2: begin
            send_gap_pct = 0;
            rsp_stall_pct = 49;
         end
         default: begin
            send_gap_pct = 11;
            rsp_stall_pct = 11;
         end
      endcase
   endtask

   initial begin
      bpu_mode_type m;
      logic [14:0] cap;
      int r;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: write mode edges, empty flush, aligned align, bad widths
      set_idle(0);
      set_stream(MODE_WRITE, 15'd16384);
      request_backlog.push_back(request_of(REQ_FIELD, 32'hFFFF_FFFF, 32, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'h1, 1, 32'h0));
      request_backlog.push_back(request_of(REQ_ALIGN, 32'h0, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_ALIGN, 32'h0, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_FLUSH, 32'h0, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_FLUSH, 32'h0, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'hFFFF_FFFF, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'hFFFF_FFFF, 33, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'hFFFF_FFFF, 63, 32'h0));
      request_backlog.push_back(request_of(REQ_BAD, 32'hFFFF_FFFF, 8, 32'hFFFF_FFFF));
      request_backlog.push_back(request_of(REQ_FIELD, 32'h5A, 7, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'h1234_5678, 32, 32'h0));

      // directed: read mode, read align, flush refused outside write mode
      set_stream(MODE_READ, 15'h7FFF);
      request_backlog.push_back(request_of(REQ_FIELD, 32'h0, 32, 32'h89AB_CDEF));
      request_backlog.push_back(request_of(REQ_FIELD, 32'h0, 3, 32'hFFFF_FFFF));
      request_backlog.push_back(request_of(REQ_ALIGN, 32'h0, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'h0, 32, 32'h0F1E_2D3C));
      request_backlog.push_back(request_of(REQ_FLUSH, 32'h0, 0, 32'h0));

      // directed: one-word buffer, refused on word position and on bit count
      set_stream(MODE_WRITE, 15'd1);
      request_backlog.push_back(request_of(REQ_FIELD, 32'h1, 1, 32'h0));
      request_backlog.push_back(request_of(REQ_FLUSH, 32'h0, 0, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'h7FFF_FFFF, 31, 32'h0));
      request_backlog.push_back(request_of(REQ_FIELD, 32'hFFFF_FFFF, 32, 32'h0));
      request_backlog.push_back(request_of(REQ_FLUSH, 32'h0, 0, 32'h0));

      // directed: empty read buffer, then the unused mode
      set_stream(MODE_READ, 15'd0);
      request_backlog.push_back(request_of(REQ_FIELD, 32'h0, 1, 32'hFFFF_FFFF));
      set_stream(MODE_BAD, 15'd16384);
      request_backlog.push_back(request_of(REQ_FIELD, 32'hFF, 8, 32'h0));

      // random phases over modes, capacities and idling
      for (int p = 0; p < 22; p++) begin
         case (p % 6)
            0, 2: m = MODE_WRITE;
            1, 3: m = MODE_READ;
            4: m = MODE_MEASURE;
            default: m = (p == 5) ? MODE_BAD : MODE_WRITE;
         endcase
         r = $urandom_range(99);
         if (r < 30) cap = 15'($urandom_range(4, 0));
         else if (r < 50) cap = 15'($urandom_range(80, 5));
         else if (r < 70) cap = 15'd16384;
         else if (r < 85) cap = 15'h7FFF;
         else cap = 15'($urandom_range(32767, 0));
         set_stream(m, cap);
         set_idle(p % 4);
         for (int i = 0; i < 75; i++) request_backlog.push_back(random_request());
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

[files.f]
rtl/bpu_pkg.sv
rtl/bit_packer_unpacker_unit.sv
test/tb.sv
